// ===== rtl/core/qfv_pkg.sv =====
// Shared types, widths and codes of the shortest-arc quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
package qfv_pkg;

    localparam int IN_WIDTH = 16;
    localparam int OUT_FRAC_BITS = 15;

    // Vector components after range reduction: magnitude up to 32768
    localparam int VW = 17;
    localparam int PW = 2 * VW;
    // Squared norm, dot product and cross product widths
    localparam int N2W = 32;
    localparam int DW = 33;
    localparam int CW = 33;
    // Unscaled quaternion magnitudes and their normalized form
    localparam int UW = 33;
    localparam int NW = 30;
    localparam int POSW = 6;

    localparam int SQ_XW = 64;
    localparam int SQ_RTW = 32;
    localparam int SQ_STEPS = SQ_XW / 2;

    localparam int DIV_STEPS = OUT_FRAC_BITS + 1;
    localparam int DIV_NUMW = NW + OUT_FRAC_BITS + 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_OPPOSITE = 2'd2
    } status_e;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] from_x;
        logic signed [IN_WIDTH-1:0] from_y;
        logic signed [IN_WIDTH-1:0] from_z;
        logic signed [IN_WIDTH-1:0] to_x;
        logic signed [IN_WIDTH-1:0] to_y;
        logic signed [IN_WIDTH-1:0] to_z;
    } vec_t;

    typedef struct packed {
        logic [OUT_FRAC_BITS-1:0]        quat_w;
        logic signed [OUT_FRAC_BITS:0]   quat_x;
        logic signed [OUT_FRAC_BITS:0]   quat_y;
        logic signed [OUT_FRAC_BITS:0]   quat_z;
        logic [1:0]                      status;
    } quat_t;

    // Carried alongside the first square root (|a||b|)
    typedef struct packed {
        logic signed [DW-1:0] d;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        status_e              status;
    } side1_t;

    // Carried alongside the second square root (quaternion norm)
    typedef struct packed {
        logic [3:0][NW-1:0] u;
        logic [2:0]         neg;
        status_e            status;
    } side2_t;

    localparam int SQ_SIDE_W = ($bits(side1_t) > $bits(side2_t)) ?
                               $bits(side1_t) : $bits(side2_t);

    typedef struct packed {
        logic [SQ_XW-1:0]     x;
        logic [SQ_SIDE_W-1:0] side;
    } sq_in_t;

    typedef struct packed {
        logic [SQ_RTW-1:0]    root;
        logic [SQ_SIDE_W-1:0] side;
    } sq_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/qfv_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qfv_sqrt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            item_valid,
    input  wire qfv_pkg::sq_in_t item,
    output logic                 result_valid,
    output qfv_pkg::sq_out_t     result
);
    localparam int XW = qfv_pkg::SQ_XW;
    localparam int RT = qfv_pkg::SQ_RTW;
    localparam int RW = RT + 3;
    localparam int STEPS = qfv_pkg::SQ_STEPS;
    localparam int SW = qfv_pkg::SQ_SIDE_W;

    logic [RW-1:0] rem_reg  [STEPS];
    logic [RT-1:0] root_reg [STEPS];
    logic [XW-1:0] x_reg    [STEPS];
    logic [SW-1:0] side_reg [STEPS];
    logic [STEPS-1:0] vld_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [RT-1:0] root_in;
        logic [XW-1:0] x_in;
        logic [SW-1:0] side_in;
        logic          v_in;
        logic [RW+1:0] cur;
        logic [RW+1:0] trial;
        logic [RW-1:0] rem_next;
        logic [RT-1:0] root_next;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = item.x;
            assign side_in = item.side;
            assign v_in    = item_valid;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign side_in = side_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        // Bring down the next two radicand bits and try root*4+1
        assign cur   = {rem_in, x_in[XW-1-2*i -: 2]};
        assign trial = (RW+2)'({root_in, 2'b01});

        always_comb
        begin
            if (cur >= trial)
            begin
                rem_next  = RW'(cur - trial);
                root_next = {root_in[RT-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RW'(cur);
                root_next = {root_in[RT-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                x_reg[i]    <= x_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign result_valid = vld_reg[STEPS-1];
    assign result.root  = root_reg[STEPS-1];
    assign result.side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/qfv_front.sv =====
// Range reduction, products, dot and cross sums and the |a|^2|b|^2 product.
`timescale 1ns / 1ps
`default_nettype none
module qfv_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          item_valid,
    input  wire qfv_pkg::vec_t item,
    output logic               result_valid,
    output qfv_pkg::sq_in_t    result
);
    localparam int W = qfv_pkg::IN_WIDTH;
    localparam int VW = qfv_pkg::VW;
    localparam int PW = qfv_pkg::PW;
    localparam int N2W = qfv_pkg::N2W;
    localparam int DW = qfv_pkg::DW;
    localparam int CW = qfv_pkg::CW;
    localparam int SW = qfv_pkg::SQ_SIDE_W;

    // Shift all three components right until the largest fits in 32768
    function automatic logic [3*VW-1:0] reduce_vec(input logic [3*W-1:0] v);
        logic [W-1:0]  comp;
        logic [W-1:0]  mag [3];
        logic [W-1:0]  m;
        logic [W-1:0]  g;
        logic [VW-1:0] gx;
        logic [3*VW-1:0] res;
        int k;
        m = '0;
        for (int i = 0; i < 3; i++)
        begin
            comp = v[i*W +: W];
            mag[i] = comp[W-1] ? (~comp + 1'b1) : comp;
            if (mag[i] > m)
                m = mag[i];
        end
        k = 0;
        for (int j = 0; j < W; j++)
        begin
            if ((m >> j) > 32768)
                k = j + 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            g  = mag[i] >> k;
            gx = VW'(g);
            res[i*VW +: VW] = v[i*W + W - 1] ? (~gx + 1'b1) : gx;
        end
        return res;
    endfunction

    // Stage 1
    logic signed [VW-1:0] a_reg [3];
    logic signed [VW-1:0] b_reg [3];
    logic                 zero_reg;
    logic                 v1_reg;
    // Stage 2
    logic signed [PW-1:0] aa_reg [3];
    logic signed [PW-1:0] bb_reg [3];
    logic signed [PW-1:0] ab_reg [3][3];
    logic                 zero2_reg;
    logic                 v2_reg;
    // Stage 3
    logic [N2W-1:0]       na2_reg;
    logic [N2W-1:0]       nb2_reg;
    logic signed [DW-1:0] d_reg;
    logic signed [CW-1:0] c_reg [3];
    logic                 zero3_reg;
    logic                 v3_reg;
    // Stage 4
    logic [qfv_pkg::SQ_XW-1:0] p_reg;
    qfv_pkg::side1_t           s1_reg;
    logic                      v4_reg;

    logic [3*VW-1:0] a_red;
    logic [3*VW-1:0] b_red;
    logic            zero_next;
    logic signed [PW-1:0] na2_sum;
    logic signed [PW-1:0] nb2_sum;
    logic signed [PW-1:0] d_sum;
    logic signed [PW-1:0] c_sum [3];
    qfv_pkg::side1_t      s1_next;

    assign a_red = reduce_vec({item.from_z, item.from_y, item.from_x});
    assign b_red = reduce_vec({item.to_z, item.to_y, item.to_x});
    assign zero_next = (item.from_x == '0 && item.from_y == '0 && item.from_z == '0) ||
                       (item.to_x == '0 && item.to_y == '0 && item.to_z == '0);

    assign na2_sum  = aa_reg[0] + aa_reg[1] + aa_reg[2];
    assign nb2_sum  = bb_reg[0] + bb_reg[1] + bb_reg[2];
    assign d_sum    = ab_reg[0][0] + ab_reg[1][1] + ab_reg[2][2];
    assign c_sum[0] = ab_reg[1][2] - ab_reg[2][1];
    assign c_sum[1] = ab_reg[2][0] - ab_reg[0][2];
    assign c_sum[2] = ab_reg[0][1] - ab_reg[1][0];

    always_comb
    begin
        s1_next.d  = d_reg;
        s1_next.cx = c_reg[0];
        s1_next.cy = c_reg[1];
        s1_next.cz = c_reg[2];
        if (zero3_reg)
            s1_next.status = qfv_pkg::ST_ZERO;
        else if (c_reg[0] == '0 && c_reg[1] == '0 && c_reg[2] == '0 && d_reg < 0)
            s1_next.status = qfv_pkg::ST_OPPOSITE;
        else
            s1_next.status = qfv_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= $signed(a_red[i*VW +: VW]);
                b_reg[i]  <= $signed(b_red[i*VW +: VW]);
                aa_reg[i] <= a_reg[i] * a_reg[i];
                bb_reg[i] <= b_reg[i] * b_reg[i];
                for (int j = 0; j < 3; j++)
                    ab_reg[i][j] <= a_reg[i] * b_reg[j];
                c_reg[i] <= CW'(c_sum[i]);
            end
            zero_reg  <= zero_next;
            zero2_reg <= zero_reg;
            zero3_reg <= zero2_reg;
            na2_reg   <= N2W'(na2_sum);
            nb2_reg   <= N2W'(nb2_sum);
            d_reg     <= DW'(d_sum);
            p_reg     <= na2_reg * nb2_reg;
            s1_reg    <= s1_next;
        end
    end

    assign result_valid = v4_reg;
    assign result.x     = p_reg;
    assign result.side  = SW'(s1_reg);

endmodule
`default_nettype wire

// ===== rtl/core/qfv_norm.sv =====
// Half-angle terms, block normalization and sum of squares of the quaternion.
`timescale 1ns / 1ps
`default_nettype none
module qfv_norm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             item_valid,
    input  wire qfv_pkg::sq_out_t item,
    output logic                  result_valid,
    output qfv_pkg::sq_in_t       result
);
    localparam int UW = qfv_pkg::UW;
    localparam int NW = qfv_pkg::NW;
    localparam int POSW = qfv_pkg::POSW;
    localparam int CW = qfv_pkg::CW;
    localparam int DW = qfv_pkg::DW;
    localparam int SW = qfv_pkg::SQ_SIDE_W;
    localparam int RT = qfv_pkg::SQ_RTW;
    localparam int WSW = RT + 3;
    localparam int SQW = 2 * NW;
    localparam int SUMW = SQW + 2;

    qfv_pkg::side1_t s1;
    logic signed [WSW-1:0] wsum;
    logic signed [CW-1:0]  c_in [3];

    // Stage 1
    logic [UW-1:0]    u1_reg [4];
    logic [2:0]       neg1_reg;
    qfv_pkg::status_e st1_reg;
    logic             v1_reg;
    // Stage 2
    logic [UW-1:0]    u2_reg [4];
    logic [POSW-1:0]  pos_reg;
    logic [2:0]       neg2_reg;
    qfv_pkg::status_e st2_reg;
    logic             v2_reg;
    // Stage 3
    logic [NW-1:0]    u3_reg [4];
    logic [2:0]       neg3_reg;
    qfv_pkg::status_e st3_reg;
    logic             v3_reg;
    // Stage 4
    logic [SQW-1:0]   sq_reg [4];
    logic [NW-1:0]    u4_reg [4];
    logic [2:0]       neg4_reg;
    qfv_pkg::status_e st4_reg;
    logic             v4_reg;
    // Stage 5
    logic [SUMW-1:0]  sum_reg;
    qfv_pkg::side2_t  s2_reg;
    logic             v5_reg;

    logic [UW-1:0]   u_next [4];
    logic [UW-1:0]   any_bits;
    logic [POSW-1:0] pos_next;
    logic [NW-1:0]   sh_next [4];
    qfv_pkg::side2_t s2_next;

    assign s1 = qfv_pkg::side1_t'(item.side[$bits(qfv_pkg::side1_t)-1:0]);
    assign c_in[0] = s1.cx;
    assign c_in[1] = s1.cy;
    assign c_in[2] = s1.cz;

    // Scalar term |a||b| + a.b, never below zero
    assign wsum = $signed({3'b000, item.root}) + $signed({{(WSW-DW){s1.d[DW-1]}}, s1.d});

    always_comb
    begin
        u_next[0] = wsum[WSW-1] ? '0 : UW'(wsum);
        for (int i = 0; i < 3; i++)
            u_next[i+1] = c_in[i][CW-1] ? UW'(~c_in[i] + 1'b1) : UW'(c_in[i]);
    end

    assign any_bits = u1_reg[0] | u1_reg[1] | u1_reg[2] | u1_reg[3];

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < UW; i++)
        begin
            if (any_bits[i])
                pos_next = POSW'(i);
        end
    end

    // Bring the largest magnitude into [2^(NW-1), 2^NW)
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (pos_reg >= POSW'(NW))
                sh_next[i] = NW'(u2_reg[i] >> (pos_reg - POSW'(NW - 1)));
            else
                sh_next[i] = NW'(u2_reg[i] << (POSW'(NW - 1) - pos_reg));
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s2_next.u[i] = u4_reg[i];
        s2_next.neg    = neg4_reg;
        s2_next.status = st4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                u1_reg[i] <= u_next[i];
                u2_reg[i] <= u1_reg[i];
                u3_reg[i] <= sh_next[i];
                sq_reg[i] <= u3_reg[i] * u3_reg[i];
                u4_reg[i] <= u3_reg[i];
            end
            neg1_reg <= {c_in[2][CW-1], c_in[1][CW-1], c_in[0][CW-1]};
            st1_reg  <= s1.status;
            pos_reg  <= pos_next;
            neg2_reg <= neg1_reg;
            st2_reg  <= st1_reg;
            neg3_reg <= neg2_reg;
            st3_reg  <= st2_reg;
            neg4_reg <= neg3_reg;
            st4_reg  <= st3_reg;
            sum_reg  <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) +
                        SUMW'(sq_reg[2]) + SUMW'(sq_reg[3]);
            s2_reg   <= s2_next;
        end
    end

    assign result_valid = v5_reg;
    assign result.x     = qfv_pkg::SQ_XW'(sum_reg);
    assign result.side  = SW'(s2_reg);

endmodule
`default_nettype wire

// ===== rtl/core/qfv_div.sv =====
// Pipelined rounded division of the four terms by the norm, then saturation.
`timescale 1ns / 1ps
`default_nettype none
module qfv_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             item_valid,
    input  wire qfv_pkg::sq_out_t item,
    output logic                  result_valid,
    output qfv_pkg::quat_t        result
);
    localparam int F = qfv_pkg::OUT_FRAC_BITS;
    localparam int RT = qfv_pkg::SQ_RTW;
    localparam int NUMW = qfv_pkg::DIV_NUMW;
    localparam int STEPS = qfv_pkg::DIV_STEPS;
    localparam logic [F-1:0] ONE = '1;

    qfv_pkg::side2_t s2;

    // Index 0 is the entry stage, 1..STEPS the quotient bits
    logic [NUMW-1:0]        rem_reg [STEPS+1][4];
    logic [STEPS-1:0]       q_reg   [STEPS+1][4];
    logic [RT-1:0]          r_reg   [STEPS+1];
    logic [2:0]             neg_reg [STEPS+1];
    qfv_pkg::status_e       st_reg  [STEPS+1];
    logic [STEPS:0]         vld_reg;
    qfv_pkg::quat_t         out_reg;
    logic                   vout_reg;

    logic [NUMW-1:0] num_next [4];
    qfv_pkg::quat_t  out_next;
    logic [F-1:0]    sat [4];

    assign s2 = qfv_pkg::side2_t'(item.side[$bits(qfv_pkg::side2_t)-1:0]);

    // Numerator with half the divisor added for round to nearest
    always_comb
    begin
        for (int l = 0; l < 4; l++)
            num_next[l] = NUMW'({s2.u[l], {F{1'b0}}}) + NUMW'(item.root >> 1);
    end

    for (genvar s = 1; s <= STEPS; s++) begin : g_step
        localparam int K = STEPS - s;
        logic [NUMW-1:0] dsh;
        logic [NUMW-1:0] rem_next [4];
        logic [STEPS-1:0] q_next [4];

        assign dsh = NUMW'(r_reg[s-1]) << K;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_next[l] = rem_reg[s-1][l];
                q_next[l]   = q_reg[s-1][l];
                if (rem_reg[s-1][l] >= dsh)
                begin
                    rem_next[l] = rem_reg[s-1][l] - dsh;
                    q_next[l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    rem_reg[s][l] <= rem_next[l];
                    q_reg[s][l]   <= q_next[l];
                end
                r_reg[s]   <= r_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                st_reg[s]  <= st_reg[s-1];
            end
        end
    end

    // Saturate, restore signs and apply the special cases
    always_comb
    begin
        for (int l = 0; l < 4; l++)
            sat[l] = (q_reg[STEPS][l] > STEPS'(ONE)) ? ONE : q_reg[STEPS][l][F-1:0];
        out_next.quat_w = sat[0];
        out_next.quat_x = neg_reg[STEPS][0] ? -$signed({1'b0, sat[1]}) : $signed({1'b0, sat[1]});
        out_next.quat_y = neg_reg[STEPS][1] ? -$signed({1'b0, sat[2]}) : $signed({1'b0, sat[2]});
        out_next.quat_z = neg_reg[STEPS][2] ? -$signed({1'b0, sat[3]}) : $signed({1'b0, sat[3]});
        out_next.status = st_reg[STEPS];
        case (st_reg[STEPS])
            qfv_pkg::ST_ZERO:
            begin
                out_next.quat_w = ONE;
                out_next.quat_x = '0;
                out_next.quat_y = '0;
                out_next.quat_z = '0;
            end
            qfv_pkg::ST_OPPOSITE:
            begin
                out_next.quat_w = '0;
                out_next.quat_x = '0;
                out_next.quat_y = '0;
                out_next.quat_z = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            vout_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[STEPS-1:0], item_valid};
            vout_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[0][l] <= num_next[l];
                q_reg[0][l]   <= '0;
            end
            r_reg[0]   <= item.root;
            neg_reg[0] <= s2.neg;
            st_reg[0]  <= s2.status;
            out_reg    <= out_next;
        end
    end

    assign result_valid = vout_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_from_two_vectors_unit.sv =====
// Shortest-arc rotation quaternion between two signed 3-D vectors, top level.
// Accepts one vector pair per clock unless stalled and returns one quaternion
// per pair, in order, through the products and sums stages, 32 stages of the
// square root that forms |a||b|, 5 normalization and sum-of-squares stages,
// 32 stages of the square root that forms the quaternion norm, and 18 stages
// of rounded division and output formatting. All stages advance together; a
// low quat_ready with a result waiting freezes the whole pipeline and also
// drops vec_ready. status reports 1 for a zero-length input (identity out)
// and 2 for exactly opposite vectors (all components zero).
`timescale 1ns / 1ps
`default_nettype none
module quaternion_from_two_vectors_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          vec_valid,
    output logic               vec_ready,
    input  wire qfv_pkg::vec_t vec_data,
    output logic               quat_valid,
    input  wire logic          quat_ready,
    output qfv_pkg::quat_t     quat_data
);
    logic             adv;
    logic             fr_valid;
    qfv_pkg::sq_in_t  fr_data;
    logic             sq1_valid;
    qfv_pkg::sq_out_t sq1_data;
    logic             nm_valid;
    qfv_pkg::sq_in_t  nm_data;
    logic             sq2_valid;
    qfv_pkg::sq_out_t sq2_data;

    // Advance whenever the output slot is empty or being taken
    assign adv       = !quat_valid || quat_ready;
    assign vec_ready = adv;

    qfv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (vec_valid),
        .item         (vec_data),
        .result_valid (fr_valid),
        .result       (fr_data)
    );

    qfv_sqrt u_sqrt_mag (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (fr_valid),
        .item         (fr_data),
        .result_valid (sq1_valid),
        .result       (sq1_data)
    );

    qfv_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (sq1_valid),
        .item         (sq1_data),
        .result_valid (nm_valid),
        .result       (nm_data)
    );

    qfv_sqrt u_sqrt_len (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (nm_valid),
        .item         (nm_data),
        .result_valid (sq2_valid),
        .result       (sq2_data)
    );

    qfv_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .item_valid   (sq2_valid),
        .item         (sq2_data),
        .result_valid (quat_valid),
        .result       (quat_data)
    );

endmodule
`default_nettype wire

// ===== tb/sv/quaternion_from_two_vectors_unit_tb.sv =====
// Self-checking testbench for the shortest-arc quaternion unit.
`timescale 1ns / 1ps
module quaternion_from_two_vectors_unit_tb;

    localparam int LATENCY = 91;
    localparam int N_RANDOM = 1500;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [qfv_pkg::OUT_FRAC_BITS-1:0] W_ONE = {qfv_pkg::OUT_FRAC_BITS{1'b1}};

    logic           clk;
    logic           rst_n;
    logic           vec_valid;
    logic           vec_ready;
    qfv_pkg::vec_t  vec_data;
    logic           quat_valid;
    logic           quat_ready;
    qfv_pkg::quat_t quat_data;

    qfv_pkg::quat_t pending_quats[$];
    int             error_count;
    longint         cycle_count;
    bit             stall_pattern_on;

    quaternion_from_two_vectors_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vec_valid  (vec_valid),
        .vec_ready  (vec_ready),
        .vec_data   (vec_data),
        .quat_valid (quat_valid),
        .quat_ready (quat_ready),
        .quat_data  (quat_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Shrink a vector so its largest magnitude is at most 32768.
    function automatic void shrink_vec(ref longint v[3]);
        longint unsigned m;
        longint unsigned g;
        int k;
        m = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
            if (mag64(v[i]) > m)
                m = mag64(v[i]);
        while ((m >> k) > 32768)
            k++;
        for (int i = 0; i < 3; i++)
        begin
            g = mag64(v[i]) >> k;
            v[i] = v[i] < 0 ? -longint'(g) : longint'(g);
        end
    endfunction

    function automatic qfv_pkg::quat_t shortest_arc(qfv_pkg::vec_t in);
        qfv_pkg::quat_t q;
        longint a[3];
        longint b[3];
        longint c[3];
        longint d;
        longint unsigned u[4];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned r;
        longint unsigned t;
        longint unsigned na2;
        longint unsigned nb2;
        longint w;
        a = '{longint'(in.from_x), longint'(in.from_y), longint'(in.from_z)};
        b = '{longint'(in.to_x), longint'(in.to_y), longint'(in.to_z)};
        q = '0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0))
        begin
            q.quat_w = W_ONE;
            q.status = qfv_pkg::ST_ZERO;
            return q;
        end
        shrink_vec(a);
        shrink_vec(b);
        na2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        nb2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        if (c[0] == 0 && c[1] == 0 && c[2] == 0 && d < 0)
        begin
            q.status = qfv_pkg::ST_OPPOSITE;
            return q;
        end
        w = longint'(int_sqrt(na2 * nb2)) + d;
        u[0] = w < 0 ? 0 : w;
        for (int i = 0; i < 3; i++)
            u[i + 1] = mag64(c[i]);
        mx = 0;
        for (int i = 0; i < 4; i++)
            if (u[i] > mx)
                mx = u[i];
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 4; i++)
                u[i] >>= 1;
            mx >>= 1;
        end
        while (mx != 0 && mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 4; i++)
                u[i] <<= 1;
            mx <<= 1;
        end
        s = 0;
        for (int i = 0; i < 4; i++)
            s += u[i] * u[i];
        r = int_sqrt(s);
        if (r == 0)
            r = 1;
        for (int i = 0; i < 4; i++)
        begin
            t = ((u[i] << qfv_pkg::OUT_FRAC_BITS) + (r >> 1)) / r;
            if (t > W_ONE)
                t = W_ONE;
            if (i == 0)
                q.quat_w = t[qfv_pkg::OUT_FRAC_BITS-1:0];
            else
            begin
                if (c[i - 1] < 0)
                    t = -t;
                case (i)
                    1: q.quat_x = t[qfv_pkg::OUT_FRAC_BITS:0];
                    2: q.quat_y = t[qfv_pkg::OUT_FRAC_BITS:0];
                    default: q.quat_z = t[qfv_pkg::OUT_FRAC_BITS:0];
                endcase
            end
        end
        q.status = qfv_pkg::ST_OK;
        return q;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // Receiver: stall on alternating random and quiet stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_ready <= 1'b0;
        else if (stall_pattern_on)
            quat_ready <= ($urandom_range(0, 3) != 0);
        else
            quat_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_pattern_on <= ~stall_pattern_on;
    end

    always @(posedge clk)
    begin
        qfv_pkg::quat_t want;
        if (rst_n && quat_valid && quat_ready)
        begin
            if (pending_quats.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = pending_quats.pop_front();
                if (quat_data.quat_w !== want.quat_w)
                    report_mismatch("quat_w", quat_data.quat_w, want.quat_w);
                if (quat_data.quat_x !== want.quat_x)
                    report_mismatch("quat_x", $signed(quat_data.quat_x), $signed(want.quat_x));
                if (quat_data.quat_y !== want.quat_y)
                    report_mismatch("quat_y", $signed(quat_data.quat_y), $signed(want.quat_y));
                if (quat_data.quat_z !== want.quat_z)
                    report_mismatch("quat_z", $signed(quat_data.quat_z), $signed(want.quat_z));
                if (quat_data.status !== want.status)
                    report_mismatch("status", quat_data.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    typedef struct {
        qfv_pkg::vec_t  v;
        bit             has_fixed;
        qfv_pkg::quat_t fixed;
    } vec_row_t;

    // Drive one transaction and hold it until accepted.
    task automatic send_vec(qfv_pkg::vec_t v);
        vec_valid <= 1'b1;
        vec_data <= v;
        pending_quats.push_back(shortest_arc(v));
        @(posedge clk);
        while (!vec_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15) - 8);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 511) - 256);
        endcase
    endfunction

    function automatic qfv_pkg::vec_t random_pair();
        qfv_pkg::vec_t v;
        int mode;
        int shape;
        logic signed [15:0] k;
        mode = $urandom_range(0, 3);
        v.from_x = rand_comp(mode);
        v.from_y = rand_comp(mode);
        v.from_z = rand_comp(mode);
        shape = $urandom_range(0, 9);
        k = 16'($urandom_range(1, 4));
        if (shape == 0)
        begin
            // negate each component, exactly opposite unless a component is -32768
            v.to_x = -v.from_x;
            v.to_y = -v.from_y;
            v.to_z = -v.from_z;
        end
        else if (shape == 1 && mode != 0 && mode != 2)
        begin
            v.to_x = v.from_x * k;
            v.to_y = v.from_y * k;
            v.to_z = v.from_z * k;
        end
        else if (shape == 2)
        begin
            v.to_x = 0;
            v.to_y = 0;
            v.to_z = 0;
        end
        else
        begin
            mode = $urandom_range(0, 3);
            v.to_x = rand_comp(mode);
            v.to_y = rand_comp(mode);
            v.to_z = rand_comp(mode);
        end
        return v;
    endfunction

    initial
    begin
        vec_row_t rows[$];
        vec_row_t row;
        qfv_pkg::quat_t z_id;
        qfv_pkg::quat_t opp;
        int gap;
        int burst;
        int drain;
        bit drained;
        error_count = 0;
        cycle_count = 0;
        stall_pattern_on = 1'b0;
        drained = 1'b0;
        rst_n = 1'b0;
        vec_valid = 1'b0;
        vec_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z_id = '0;
        z_id.quat_w = W_ONE;
        z_id.status = qfv_pkg::ST_ZERO;
        opp = '0;
        opp.status = qfv_pkg::ST_OPPOSITE;
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3}, 1'b1, z_id});
        rows.push_back('{'{16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, z_id});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, z_id});
        rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b1, opp});
        rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8001, 16'sh8001, 16'sh8001},
                         1'b1, opp});
        rows.push_back('{'{16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0}, 1'b1, opp});
        rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, z_id});
        rows.push_back('{'{16'sd3, 16'sd4, 16'sd0, 16'sd6, 16'sd8, 16'sd0}, 1'b0, z_id});
        rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
                         1'b0, z_id});
        rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sd0, 16'sh8000, 16'sh7fff, 16'sd0},
                         1'b0, z_id});
        rows.push_back('{'{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, z_id});
        rows.push_back('{'{16'sd1, 16'sd0, 16'sd0, 16'sh8000, 16'sd1, 16'sd0}, 1'b0, z_id});
        rows.push_back('{'{16'shffff, 16'shffff, 16'shffff, 16'sd1, 16'sd1, 16'sd2}, 1'b0, z_id});
        rows.push_back('{'{16'sd1, 16'sd1, 16'sd1, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, z_id});
        foreach (rows[i])
        begin
            row = rows[i];
            if (row.has_fixed && shortest_arc(row.v) != row.fixed)
                report_mismatch("table row", i, i);
            send_vec(row.v);
        end

        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++)
                send_vec(random_pair());
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (!drained && n >= N_RANDOM / 2)
            begin
                // hold off until the pipeline is empty
                drained = 1'b1;
                vec_valid <= 1'b0;
                while (pending_quats.size() != 0)
                    @(posedge clk);
            end
            else if (gap != 0)
            begin
                vec_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        vec_valid <= 1'b0;
        while (pending_quats.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < 2 * LATENCY; drain++)
            @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
